// ===== rtl/lrp_pkg.sv =====
package lrp_pkg;

    localparam int VALUE_BITS  = 63;
    localparam int OFFSET_BITS = 32;
    localparam int SUM_BITS    = (VALUE_BITS > OFFSET_BITS) ? VALUE_BITS : OFFSET_BITS;
    localparam int SCALED_BITS = VALUE_BITS + 4;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_L     = 8'h6C;
    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_E     = 8'h65;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_N     = 8'h6E;

    localparam logic [2:0] CLS_L     = 3'd0;
    localparam logic [2:0] CLS_BE    = 3'd1;
    localparam logic [2:0] CLS_AN    = 3'd2;
    localparam logic [2:0] CLS_DIGIT = 3'd3;
    localparam logic [2:0] CLS_COMMA = 3'd4;
    localparam logic [2:0] CLS_OTHER = 3'd5;

    localparam logic [2:0] ST_SEEK = 3'd0;
    localparam logic [2:0] ST_L    = 3'd1;
    localparam logic [2:0] ST_BE   = 3'd2;
    localparam logic [2:0] ST_AN   = 3'd3;
    localparam logic [2:0] ST_NUM  = 3'd4;

    localparam logic [1:0] STATUS_LBA_BAD = 2'b01;
    localparam logic [1:0] STATUS_LEN_BAD = 2'b10;

    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] digit;
    } lrp_entry_t;

endpackage

// ===== rtl/lrp_front.sv =====
module lrp_front
    import lrp_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       queue_full,
    output logic       push,
    output lrp_entry_t push_entry
);

    logic skip;

    assign in_ready = !queue_full;
    assign skip     = (in_byte == CHAR_SPACE) || (in_byte == CHAR_COLON);
    assign push     = in_valid && in_ready && !skip;

    always_comb
    begin
        push_entry.digit = in_byte[3:0];
        case (in_byte) inside
            CHAR_L:
                push_entry.cls = CLS_L;
            CHAR_B, CHAR_E:
                push_entry.cls = CLS_BE;
            CHAR_A, CHAR_N:
                push_entry.cls = CLS_AN;
            [CHAR_ZERO:CHAR_NINE]:
                push_entry.cls = CLS_DIGIT;
            CHAR_COMMA:
                push_entry.cls = CLS_COMMA;
            default:
                push_entry.cls = CLS_OTHER;
        endcase
    end

endmodule

// ===== rtl/lrp_queue.sv =====
module lrp_queue
    import lrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  lrp_entry_t push_entry,
    output logic       full,
    output logic       head_valid,
    output lrp_entry_t head_entry,
    input  logic       pop
);

    lrp_entry_t                store_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] cnt_reg, cnt_next;

    function automatic logic [QUEUE_PTR_BITS-1:0] ptr_inc(input logic [QUEUE_PTR_BITS-1:0] p);
        if (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    assign full       = (cnt_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("item pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("item popped from an empty queue");

endmodule

// ===== rtl/lrp_back.sv =====
module lrp_back
    import lrp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  lrp_entry_t             head_entry,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_BITS-1:0]  lba_value,
    output logic [VALUE_BITS-1:0]  length_value,
    output logic [OFFSET_BITS-1:0] start_offset,
    output logic [1:0]             record_status
);

    logic [2:0]             state_reg, state_next;
    logic [VALUE_BITS-1:0]  accum_reg, accum_next;
    logic                   has_reg, has_next;
    logic                   ovf_reg, ovf_next;
    logic [VALUE_BITS-1:0]  lba_hold_reg, lba_hold_next;
    logic                   lba_inv_reg, lba_inv_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                   out_valid_reg;
    logic [VALUE_BITS-1:0]  lba_out_reg;
    logic [VALUE_BITS-1:0]  len_out_reg;
    logic [OFFSET_BITS-1:0] off_out_reg;
    logic [1:0]             status_out_reg;

    logic [SCALED_BITS-1:0] scaled;
    logic                   scaled_ovf;
    logic                   num_bad;
    logic [VALUE_BITS-1:0]  num_value;
    logic [SUM_BITS-1:0]    len_wide;
    logic                   emit;

    assign scaled = (SCALED_BITS'(accum_reg) << 3) + (SCALED_BITS'(accum_reg) << 1)
                  + SCALED_BITS'(head_entry.digit);
    assign scaled_ovf = |scaled[SCALED_BITS-1:VALUE_BITS];
    assign num_bad    = !has_reg || ovf_reg;
    assign num_value  = num_bad ? '0 : accum_reg;
    assign len_wide   = SUM_BITS'(num_value);

    assign emit = (state_reg == ST_NUM) && ((head_entry.cls == CLS_OTHER)
               || (head_entry.cls == CLS_BE) || (head_entry.cls == CLS_AN));
    assign pop  = head_valid && (!emit || !out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        accum_next    = accum_reg;
        has_next      = has_reg;
        ovf_next      = ovf_reg;
        lba_hold_next = lba_hold_reg;
        lba_inv_next  = lba_inv_reg;
        offset_next   = offset_reg;
        if (pop)
        begin
            case (head_entry.cls)
                CLS_L:
                    state_next = ST_L;
                CLS_BE:
                    if (state_reg == ST_L)
                        state_next = ST_BE;
                CLS_AN:
                    if (state_reg == ST_BE)
                        state_next = ST_AN;
                CLS_DIGIT:
                    if (state_reg == ST_AN || state_reg == ST_NUM)
                    begin
                        state_next = ST_NUM;
                        has_next   = 1'b1;
                        if (!ovf_reg)
                        begin
                            if (scaled_ovf)
                                ovf_next = 1'b1;
                            else
                                accum_next = scaled[VALUE_BITS-1:0];
                        end
                    end
                CLS_COMMA:
                    if (state_reg == ST_NUM)
                    begin
                        lba_inv_next  = num_bad;
                        lba_hold_next = num_value;
                        accum_next    = '0;
                        has_next      = 1'b0;
                        ovf_next      = 1'b0;
                    end
                default:
                    ;
            endcase
            if (emit)
            begin
                offset_next = offset_reg + OFFSET_BITS'(len_wide);
                accum_next  = '0;
                has_next    = 1'b0;
                ovf_next    = 1'b0;
                state_next  = ST_SEEK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SEEK;
            accum_reg     <= '0;
            has_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            lba_hold_reg  <= '0;
            lba_inv_reg   <= 1'b1;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            accum_reg    <= accum_next;
            has_reg      <= has_next;
            ovf_reg      <= ovf_next;
            lba_hold_reg <= lba_hold_next;
            lba_inv_reg  <= lba_inv_next;
            offset_reg   <= offset_next;
            if (pop && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            lba_out_reg    <= lba_hold_reg;
            len_out_reg    <= num_value;
            off_out_reg    <= offset_reg;
            status_out_reg <= (lba_inv_reg ? STATUS_LBA_BAD : 2'b00)
                            | (num_bad ? STATUS_LEN_BAD : 2'b00);
        end
    end

    assign out_valid     = out_valid_reg;
    assign lba_value     = lba_out_reg;
    assign length_value  = len_out_reg;
    assign start_offset  = off_out_reg;
    assign record_status = status_out_reg;

    a_emit_to_seek: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && emit) |=> (state_reg == ST_SEEK) && out_valid_reg)
        else $error("record closed without returning to search");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !has_reg |-> (accum_reg == '0) && !ovf_reg)
        else $error("number state inconsistent with no digits");

    a_bad_lba_zero: assert property (@(posedge clk) disable iff (!rst_n)
        lba_inv_reg |-> (lba_hold_reg == '0))
        else $error("invalid LBA holds a non-zero value");

endmodule

// ===== rtl/lba_len_record_parser.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_byte
// out      output     out_valid/out_ready  lba_value, length_value, start_offset,
//                                          record_status
//
// One item is taken per cycle while the queue has room; the back end works one queued
// item per cycle unless a record waits, and registers a record on its closing item.
// A two-entry queue parts the byte classifier from the number and offset logic.
// Reset clears the search state, the number, the held LBA and the offset.
// A waiting record holds back the next closing item; the queue then fills and stalls input.
module lba_len_record_parser
    import lrp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_BITS-1:0]  lba_value,
    output logic [VALUE_BITS-1:0]  length_value,
    output logic [OFFSET_BITS-1:0] start_offset,
    output logic [1:0]             record_status
);

    logic       queue_full;
    logic       push;
    lrp_entry_t push_entry;
    logic       head_valid;
    lrp_entry_t head_entry;
    logic       pop;

    lrp_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    lrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    lrp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lba_value     (lba_value),
        .length_value  (length_value),
        .start_offset  (start_offset),
        .record_status (record_status)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import lrp_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          REPORT_LIMIT = 10;
    localparam logic [1:0]  STATUS_OK    = 2'b00;
    localparam logic [63:0] VALUE_LIMIT  = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [7:0]  CHAR_NL      = 8'h0A;
    localparam logic [7:0]  CHAR_SEMI    = 8'h3B;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  lba;
        logic [VALUE_BITS-1:0]  length;
        logic [OFFSET_BITS-1:0] offset;
        logic [1:0]             status;
    } record_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             in_byte = 8'h00;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [VALUE_BITS-1:0]  lba_value;
    logic [VALUE_BITS-1:0]  length_value;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [1:0]             record_status;

    logic [2:0]             scan_state = ST_SEEK;
    logic [VALUE_BITS-1:0]  digits_acc = '0;
    logic                   digits_seen = 1'b0;
    logic                   digits_ovf = 1'b0;
    logic [VALUE_BITS-1:0]  held_lba = '0;
    logic                   held_lba_bad = 1'b1;
    logic [OFFSET_BITS-1:0] offset_sum = '0;

    record_t expected_records[$];

    int error_cnt = 0;
    int cycle_cnt = 0;
    int bytes_sent = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;

    lba_len_record_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lba_value     (lba_value),
        .length_value  (length_value),
        .start_offset  (start_offset),
        .record_status (record_status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic clear_digits();
        digits_acc = '0;
        digits_seen = 1'b0;
        digits_ovf = 1'b0;
    endtask

    task automatic predict_byte(input logic [7:0] c);
        logic        is_digit;
        logic        len_bad;
        logic [63:0] d;
        record_t     rec;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        if (c == CHAR_SPACE || c == CHAR_COLON)
        begin
        end
        else if (c == CHAR_L)
        begin
            scan_state = ST_L;
        end
        else if ((c == CHAR_B || c == CHAR_E) && scan_state == ST_L)
        begin
            scan_state = ST_BE;
        end
        else if ((c == CHAR_A || c == CHAR_N) && scan_state == ST_BE)
        begin
            scan_state = ST_AN;
        end
        else if ((scan_state == ST_AN || scan_state == ST_NUM) && is_digit)
        begin
            d = 64'(c - CHAR_ZERO);
            scan_state = ST_NUM;
            digits_seen = 1'b1;
            if (!digits_ovf)
            begin
                if (64'(digits_acc) > (VALUE_LIMIT - d) / 64'd10)
                    digits_ovf = 1'b1;
                else
                    digits_acc = VALUE_BITS'(64'(digits_acc) * 64'd10 + d);
            end
        end
        else if (scan_state == ST_NUM && c == CHAR_COMMA)
        begin
            held_lba_bad = !digits_seen || digits_ovf;
            held_lba = held_lba_bad ? '0 : digits_acc;
            clear_digits();
        end
        else if (scan_state == ST_NUM && !is_digit)
        begin
            len_bad = !digits_seen || digits_ovf;
            rec.lba = held_lba_bad ? '0 : held_lba;
            rec.length = len_bad ? '0 : digits_acc;
            rec.offset = offset_sum;
            rec.status = (held_lba_bad ? STATUS_LBA_BAD : STATUS_OK)
                       | (len_bad ? STATUS_LEN_BAD : STATUS_OK);
            expected_records.push_back(rec);
            offset_sum = offset_sum + OFFSET_BITS'(rec.length);
            clear_digits();
            scan_state = ST_SEEK;
        end
    endtask

    always @(posedge clk)
    begin : record_checker
        record_t got;
        record_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {lba_value, length_value, start_offset, record_status};
            if (expected_records.size() == 0)
            begin
                error_cnt++;
                if (error_cnt <= REPORT_LIMIT)
                    $display("Unexpected record: lba %0d len %0d offset %0d status %0d",
                             got.lba, got.length, got.offset, got.status);
            end
            else
            begin
                want = expected_records.pop_front();
                if (got !== want)
                begin
                    error_cnt++;
                    if (error_cnt <= REPORT_LIMIT)
                    begin
                        $display("Mismatch: expected lba %0d len %0d offset %0d status %0d",
                                 want.lba, want.length, want.offset, want.status);
                        $display("          got lba %0d len %0d offset %0d status %0d",
                                 got.lba, got.length, got.offset, got.status);
                    end
                end
            end
        end
        if (rst_n && in_valid && in_ready)
            predict_byte(in_byte);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        in_byte = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_gap();
        repeat ($urandom_range(2))
            send_byte($urandom_range(1) ? CHAR_SPACE : CHAR_COLON);
    endtask

    task automatic send_digits(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_byte(CHAR_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(19) == 0)
                send_byte(CHAR_SPACE);
        end
    endtask

    task automatic send_number();
        int kind;
        kind = $urandom_range(19);
        case (kind)
            0: ;
            1: send_text("9223372036854775807");
            2: send_text("9223372036854775808");
            3: send_digits($urandom_range(20, 24));
            4, 5: send_digits(19);
            6: send_byte(CHAR_ZERO);
            7: send_digits($urandom_range(9, 12));
            default: send_digits($urandom_range(1, 6));
        endcase
    endtask

    task automatic send_end();
        logic [7:0] b;
        case ($urandom_range(5))
            0: b = CHAR_NL;
            1: b = CHAR_SEMI;
            2: b = CHAR_B;
            default:
            begin
                b = 8'($urandom_range(255));
                while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_SPACE
                       || b == CHAR_COLON || b == CHAR_L || b == CHAR_COMMA)
                    b = 8'($urandom_range(255));
            end
        endcase
        send_byte(b);
    endtask

    task automatic send_record();
        if ($urandom_range(9) != 0)
        begin
            send_text("lba");
            send_gap();
            send_number();
            if ($urandom_range(19) == 0)
                send_byte(CHAR_COMMA);
            send_byte(CHAR_COMMA);
            send_gap();
        end
        send_text("len");
        send_gap();
        send_number();
        if ($urandom_range(19) == 0)
        begin
            send_text("len");
            send_number();
        end
        send_end();
    endtask

    task automatic send_fragment();
        case ($urandom_range(5))
            0: send_text("l");
            1: send_text("lb");
            2: send_text("le");
            3: send_text("lba");
            4: send_text("len");
            default: send_text("lban");
        endcase
        if ($urandom_range(1))
            send_digits($urandom_range(1, 3));
    endtask

    task automatic run_random(input int nbytes);
        int first;
        int pick;
        first = bytes_sent;
        while (bytes_sent - first < nbytes)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_record();
            else if (pick < 85)
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(255)));
            else
                send_fragment();
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        send_text("len 1:2;");
        send_text("lba7,x");
        send_text("len4len5x");
        send_text("lba0,len0");
        send_byte(8'hFF);
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        stall_pct = 0;
        run_random(300);
    endtask

    task automatic test_sender_idle();
        send_idle_pct = 67;
        stall_pct = 0;
        run_random(300);
    endtask

    task automatic test_receiver_stall();
        send_idle_pct = 0;
        stall_pct = 67;
        run_random(300);
    endtask

    task automatic test_both_idle();
        send_idle_pct = 12;
        stall_pct = 12;
        run_random(300);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b1;
        run_random(100);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        stall_pct = 0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_records.size() != 0)
            error_cnt++;
        if (error_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== lba_len_record_parser.f =====
rtl/lrp_pkg.sv
rtl/lrp_front.sv
rtl/lrp_queue.sv
rtl/lrp_back.sv
rtl/lba_len_record_parser.sv
tb/sv/tb_top.sv
